### hdl/rgbhsl_pkg.sv
// Package for the RGB to HSL converter: constants, the divider lane type and
// the one-bit restoring division step shared by every cell of the chain.
// Depends on nothing.
package rgbhsl_pkg;

   localparam int unsigned HSL_FULL  = 255;
   localparam int unsigned HUE_GREY  = (HSL_FULL * 2) / 3;
   localparam int unsigned HUE_SIXTH = HSL_FULL / 6;
   localparam int unsigned HUE_THIRD = HSL_FULL / 3;
   localparam int unsigned DIV_STEPS = 8;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   // One long division in flight: partial remainder, numerator bits still to
   // bring down, divisor and quotient built so far.
   typedef struct packed {
      logic [8:0] rem;
      logic [7:0] low;
      logic [8:0] den;
      logic [7:0] quo;
   } lane_type;

   typedef struct packed {
      lane_type   sat;
      lane_type   dr;
      lane_type   dg;
      lane_type   db;
      logic [7:0] light;
      logic       grey;
      sector_type sector;
   } work_type;

   function automatic lane_type div_step(lane_type l);
      lane_type   n;
      logic [9:0] t;
      n     = l;
      t     = {l.rem, l.low[7]};
      n.low = {l.low[6:0], 1'b0};
      if (t >= {1'b0, l.den}) begin
         n.rem = 9'(t - {1'b0, l.den});
         n.quo = {l.quo[6:0], 1'b1};
      end else begin
         n.rem = t[8:0];
         n.quo = {l.quo[6:0], 1'b0};
      end
      return n;
   endfunction

endpackage

### hdl/rgbhsl_if.sv
// Handshake interfaces for the RGB to HSL converter: request and response.
// Depends on nothing.
interface rgbhsl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsl_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] hue;
   logic [7:0] saturation;
   logic [7:0] lightness;
   modport source (output valid, output hue, output saturation, output lightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input lightness,
                   output ready);
endinterface

### hdl/rgbhsl_prep.sv
// Front stage: max, min, lightness and the four division operands.
// Depends on rgbhsl_pkg.
module rgbhsl_prep (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [7:0]           red,
   input  logic [7:0]           green,
   input  logic [7:0]           blue,
   output logic                 out_valid,
   output rgbhsl_pkg::work_type out_work
);
   import rgbhsl_pkg::*;

   logic [7:0]  hi, lo, spread;
   logic [8:0]  sum, sat_den;
   logic [7:0]  light;
   logic [15:0] sat_num, dr_num, dg_num, db_num;
   logic        valid_ff;
   work_type    work_ff, work_in;

   function automatic logic [15:0] hue_num(logic [7:0] top, logic [7:0] chan,
                                           logic [7:0] spr);
      logic [15:0] prod;
      prod = 16'(8'(top - chan)) * 16'(HUE_SIXTH);
      return 16'(prod + 16'(spr[7:1]));
   endfunction

   always_comb begin
      hi = (red > green) ? red : green;
      lo = (red < green) ? red : green;
      if (blue > hi) hi = blue;
      if (blue < lo) lo = blue;
      sum     = 9'(hi) + 9'(lo);
      light   = 8'((10'(sum) + 10'd1) >> 1);
      spread  = 8'(hi - lo);
      sat_den = (light <= 8'(HSL_FULL / 2)) ? sum : 9'(10'(2 * HSL_FULL) - 10'(sum));
      sat_num = 16'(({8'd0, spread} << 8) - {8'd0, spread} + 16'(sat_den[8:1]));
      dr_num  = hue_num(hi, red, spread);
      dg_num  = hue_num(hi, green, spread);
      db_num  = hue_num(hi, blue, spread);

      work_in.sat = '{rem: {1'b0, sat_num[15:8]}, low: sat_num[7:0], den: sat_den, quo: '0};
      work_in.dr  = '{rem: {1'b0, dr_num[15:8]}, low: dr_num[7:0], den: {1'b0, spread},
                      quo: '0};
      work_in.dg  = '{rem: {1'b0, dg_num[15:8]}, low: dg_num[7:0], den: {1'b0, spread},
                      quo: '0};
      work_in.db  = '{rem: {1'b0, db_num[15:8]}, low: db_num[7:0], den: {1'b0, spread},
                      quo: '0};
      work_in.light = light;
      work_in.grey  = (hi == lo);
      if (red == hi)        work_in.sector = SECTOR_RED;
      else if (green == hi) work_in.sector = SECTOR_GREEN;
      else                  work_in.sector = SECTOR_BLUE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;
endmodule

### hdl/rgbhsl_cell.sv
// One cell of the division chain: one quotient bit for each of the four lanes.
// Depends on rgbhsl_pkg.
module rgbhsl_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  rgbhsl_pkg::work_type in_work,
   output logic                 out_valid,
   output rgbhsl_pkg::work_type out_work
);
   import rgbhsl_pkg::*;

   logic     valid_ff;
   work_type work_ff, work_in;

   always_comb begin
      work_in     = in_work;
      work_in.sat = div_step(in_work.sat);
      work_in.dr  = div_step(in_work.dr);
      work_in.dg  = div_step(in_work.dg);
      work_in.db  = div_step(in_work.db);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;
endmodule

### hdl/rgb_to_hsl_integer_unit.sv
// Top level of the RGB to HSL converter: front stage, division chain, output.
// Depends on rgbhsl_pkg, rgbhsl_if, rgbhsl_prep and rgbhsl_cell.
//
// Usage. Requests arrive on req_bus carrying one 8-bit red, green and blue
// pixel; each request yields exactly one response on rsp_bus with hue,
// saturation and lightness, all scaled 0 to 255, in request order.
// A request is taken at a rising edge with valid and ready both high.
// Pipeline: the front stage registers a request at the edge that takes it,
// then eight division cells and one output register follow.
// Throughput: one request per cycle while the output is not stalled; the
// eight cells each settle one quotient bit of four restoring divisions, so
// eight requests are in flight at once inside the chain.
// Stalls: the whole pipe moves as one. When the output register holds a
// response that is not taken, every stage holds and req_bus.ready drops;
// it rises again in the cycle the response is taken.
// Reset: synchronous and active high; it empties the pipe, and no response
// is presented until new requests have been taken.
module rgb_to_hsl_integer_unit (
   input logic         clock,
   input logic         reset,
   rgbhsl_req_if.sink   req_bus,
   rgbhsl_rsp_if.source rsp_bus
);
   import rgbhsl_pkg::*;

   logic       advance;
   logic       stage_valid [DIV_STEPS+1];
   work_type   stage_work  [DIV_STEPS+1];
   logic       rsp_valid_ff;
   logic [7:0] hue_ff, sat_ff, light_ff;
   logic [7:0] hue_in;
   logic [8:0] hue_wide;
   work_type   last;

   // The pipe advances whenever the output register is free or being emptied.
   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   rgbhsl_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_bus.valid),
      .red       (req_bus.red),
      .green     (req_bus.green),
      .blue      (req_bus.blue),
      .out_valid (stage_valid[0]),
      .out_work  (stage_work[0])
   );

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      rgbhsl_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[i]),
         .in_work   (stage_work[i]),
         .out_valid (stage_valid[i+1]),
         .out_work  (stage_work[i+1])
      );
   end

   assign last = stage_work[DIV_STEPS];

   // The hue deltas never exceed a sixth of a turn, so each sector lands
   // in its own range and no wrap beyond a full turn can occur. A negative
   // red-sector hue is lifted by a full turn.
   always_comb begin
      unique case (last.sector)
         SECTOR_RED: begin
            if (last.db.quo >= last.dg.quo) begin
               hue_wide = 9'(last.db.quo) - 9'(last.dg.quo);
            end else begin
               hue_wide = 9'(HSL_FULL) + 9'(last.db.quo) - 9'(last.dg.quo);
            end
         end
         SECTOR_GREEN: begin
            hue_wide = 9'(HUE_THIRD) + 9'(last.dr.quo) - 9'(last.db.quo);
         end
         SECTOR_BLUE: begin
            hue_wide = 9'(HUE_GREY) + 9'(last.dg.quo) - 9'(last.dr.quo);
         end
         default: begin
            hue_wide = 9'(HUE_GREY);
         end
      endcase
      hue_in = last.grey ? 8'(HUE_GREY) : hue_wide[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stage_valid[DIV_STEPS];
      end
      if (advance) begin
         hue_ff   <= hue_in;
         sat_ff   <= last.grey ? 8'd0 : last.sat.quo;
         light_ff <= last.light;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.hue        = hue_ff;
   assign rsp_bus.saturation = sat_ff;
   assign rsp_bus.lightness  = light_ff;

`ifndef SYNTH
   // Hue deltas leaving the chain are bounded by a sixth of a turn.
   a_delta_bound: assert property (@(posedge clock) disable iff (reset)
      stage_valid[DIV_STEPS] && !last.grey |->
         (last.dr.quo <= 8'(HUE_SIXTH)) && (last.dg.quo <= 8'(HUE_SIXTH)) &&
         (last.db.quo <= 8'(HUE_SIXTH)))
      else $error("hue delta out of range");

   // A coloured pixel always has non-zero saturation.
   a_sat_nonzero: assert property (@(posedge clock) disable iff (reset)
      advance && stage_valid[DIV_STEPS] && !last.grey |=> rsp_bus.saturation != 8'd0)
      else $error("zero saturation for a coloured pixel");

   // Green-sector hue stays within its third of the circle.
   a_green_range: assert property (@(posedge clock) disable iff (reset)
      advance && stage_valid[DIV_STEPS] && !last.grey && last.sector == SECTOR_GREEN |=>
         (rsp_bus.hue >= 8'd43) && (rsp_bus.hue <= 8'd127))
      else $error("green-sector hue out of range");

   // A held response and the front stage's valid bit keep their values while the pipe is stalled.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(hue_ff) && $stable(sat_ff) && $stable(light_ff) &&
                   $stable(stage_valid[0]))
      else $error("pipe moved during a stall");
`endif
endmodule
